// ----- rtl/core/iwe_pkg.sv -----
// Package: shared constants, types and helpers for the indexed word enumerator.
package iwe_pkg;

  localparam int MAX_WORD_LEN = 8;
  localparam int ALPHABET_MAX = 40;
  localparam int ALPHA_REGS   = 5;
  localparam int IDX_W        = 43;
  // 40^8 needs 43 bits; start sums stay below 2^44
  localparam int CNT_W        = 45;
  localparam int DIG_W        = 6;
  localparam int LEN_W        = 4;
  localparam int NUM_REGS     = 8;
  localparam int ADDR_W       = 6;

  // Reciprocal of n, ceil(2^RCP_SH / n): exact quotient for any 43-bit
  // offset, since the rounding error times the offset stays below 2^RCP_SH.
  localparam int RCP_SH       = 49;
  localparam int RCP_W        = 50;
  localparam int SPLIT_W      = 25;
  localparam int PROD_W       = IDX_W + SPLIT_W;
  localparam int SUM_W        = PROD_W + SPLIT_W;

  // Cycles for the power and group-start tables to rebuild after a write.
  localparam int SETTLE_CYC   = 9;

  typedef enum logic [2:0] {
    REG_ALPHA0    = 3'd0,
    REG_ALPHA1    = 3'd1,
    REG_ALPHA2    = 3'd2,
    REG_ALPHA3    = 3'd3,
    REG_ALPHA4    = 3'd4,
    REG_ALPHA_SZ  = 3'd5,
    REG_MIN_LEN   = 3'd6,
    REG_MAX_LEN   = 3'd7
  } reg_idx_t;

  // Effective configuration after saturation.
  typedef struct packed {
    logic [DIG_W-1:0] n;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    logic             empty;
  } cfg_eff_t;

  // Word travelling through the digit chain.
  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] rem;
    logic [63:0]      bytes;
  } dig_word_t;

  typedef logic [ALPHABET_MAX:0][RCP_W-1:0] recip_tab_t;

  function automatic recip_tab_t make_recip_tab();
    recip_tab_t  t;
    logic [63:0] one;
    one  = 64'd1 << RCP_SH;
    t[0] = '0;
    for (int i = 1; i <= ALPHABET_MAX; i++) begin
      t[i] = RCP_W'((one + 64'(i) - 64'd1) / 64'(i));
    end
    return t;
  endfunction

  localparam recip_tab_t RECIP_TAB = make_recip_tab();

endpackage

// ----- rtl/core/iwe_locate.sv -----
// Length-group search: finds the group holding the index, two pipeline stages.
module iwe_locate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        v_in,
  input  logic [iwe_pkg::IDX_W-1:0]   idx_in,
  input  iwe_pkg::cfg_eff_t           cfg,
  output logic                        v_out,
  output iwe_pkg::dig_word_t          w_out
);
  import iwe_pkg::*;

  // powers n^1..n^8 are built from config, registered (the user keeps config static while busy; not enforced here)
  logic [CNT_W-1:0] pw_r [1:MAX_WORD_LEN];
  logic [CNT_W-1:0] st_r [1:MAX_WORD_LEN+1]; // start of group l (cumulative from lo)

  always_ff @(posedge clk) begin
    pw_r[1] <= CNT_W'(cfg.n);
    for (int l = 2; l <= MAX_WORD_LEN; l++) begin
      pw_r[l] <= CNT_W'(pw_r[l-1] * CNT_W'(cfg.n));
    end
    st_r[1] <= '0;
    for (int l = 1; l <= MAX_WORD_LEN; l++) begin
      st_r[l+1] <= (LEN_W'(l) >= cfg.lo) ? st_r[l] + pw_r[l] : '0;
    end
  end

  // stage 1: compare against group ends
  logic                        v1_r;
  logic [IDX_W-1:0]            idx1_r;
  logic [MAX_WORD_LEN:1]       below_r;
  logic [MAX_WORD_LEN:1]       below_nxt;

  always_comb begin
    for (int l = 1; l <= MAX_WORD_LEN; l++) begin
      below_nxt[l] = !cfg.empty && (LEN_W'(l) >= cfg.lo) && (LEN_W'(l) <= cfg.hi) &&
                     (CNT_W'(idx_in) < st_r[l+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
    end
    if (en) begin
      idx1_r  <= idx_in;
      below_r <= below_nxt;
    end
  end

  // stage 2: pick lowest group, subtract its start
  logic [LEN_W-1:0] len_c;
  always_comb begin
    len_c = '0;
    for (int l = MAX_WORD_LEN; l >= 1; l--) begin
      if (below_r[l]) len_c = LEN_W'(l);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v1_r;
    end
    if (en) begin
      w_out.ok    <= (len_c != '0);
      w_out.len   <= len_c;
      w_out.rem   <= (len_c != '0) ? CNT_W'(idx1_r) - st_r[len_c] : '0;
      w_out.bytes <= '0;
    end
  end

endmodule

// ----- rtl/core/iwe_digit.sv -----
// One digit stage: peels off a base-n digit and maps it through the alphabet.
module iwe_digit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [2:0]                  pos,
  input  logic                        v_in,
  input  iwe_pkg::dig_word_t          w_in,
  input  logic [iwe_pkg::DIG_W-1:0]   n,
  input  logic [iwe_pkg::RCP_W-1:0]   recip,
  input  logic [8*iwe_pkg::ALPHABET_MAX-1:0] alpha,
  output logic                        v_out,
  output iwe_pkg::dig_word_t          w_out
);
  import iwe_pkg::*;

  // first stage: rem times the reciprocal, as two half-width products
  logic              va_r;
  dig_word_t         wa_r;
  logic [PROD_W-1:0] plo_r;
  logic [PROD_W-1:0] phi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
    end
    if (en) begin
      wa_r  <= w_in;
      plo_r <= PROD_W'(w_in.rem[IDX_W-1:0]) * PROD_W'(recip[SPLIT_W-1:0]);
      phi_r <= PROD_W'(w_in.rem[IDX_W-1:0]) * PROD_W'(recip[RCP_W-1:SPLIT_W]);
    end
  end

  // second stage: exact quotient, digit = rem - q*n, character lookup
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] q;
  logic [CNT_W-1:0] r0;
  logic [DIG_W-1:0] d;
  logic [7:0]       ch;

  always_comb begin
    sum = {phi_r, SPLIT_W'(0)} + SUM_W'(plo_r);
    q   = CNT_W'(sum >> RCP_SH);
    r0  = wa_r.rem - CNT_W'(q * CNT_W'(n));
    d   = r0[DIG_W-1:0];
    ch  = alpha[8*d +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= va_r;
    end
    if (en) begin
      w_out <= wa_r;
      if (wa_r.ok && (LEN_W'(pos) < wa_r.len)) begin
        w_out.rem             <= q;
        w_out.bytes[8*pos +: 8] <= ch;
      end
    end
  end

endmodule

// ----- rtl/core/indexed_word_enumerator_unit.sv -----
// Top level: APB configuration, pipeline of group search and eight digit stages.
// Indexed word enumerator. An index arriving on in_ returns the index-th word of the
// list of all words over the configured alphabet, grouped by length min..max, first
// character varying fastest. One word can be accepted per cycle while the output is
// not stalled; the length search is followed, per character position, by a split
// reciprocal multiply and then the digit and its character, out_tdata coming straight
// from the last stage. The stall moves the whole chain together. Configuration must be
// written only when the pipeline is empty; after reset and after every register write
// in_tready stays low while the powers and group starts are rebuilt.
// pready is always high; reads return register values.
module indexed_word_enumerator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [iwe_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [42:0] word_index, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [0] in_range, [4:1] word_length, [68:5] word_bytes
);
  import iwe_pkg::*;

  logic [63:0]      alpha_r [ALPHA_REGS];
  logic [DIG_W-1:0] asz_r;
  logic [LEN_W-1:0] minl_r;
  logic [LEN_W-1:0] maxl_r;
  reg_idx_t         ri;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign ri = reg_idx_t'(cfg_paddr[5:3]);
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2:0] == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHA_REGS; i++) alpha_r[i] <= '0;
      asz_r  <= DIG_W'(1);
      minl_r <= LEN_W'(1);
      maxl_r <= LEN_W'(8);
    end else if (wr) begin
      unique case (ri)
        REG_ALPHA0, REG_ALPHA1, REG_ALPHA2, REG_ALPHA3, REG_ALPHA4:
          alpha_r[ri] <= cfg_pwdata;
        REG_ALPHA_SZ: asz_r  <= cfg_pwdata[DIG_W-1:0];
        REG_MIN_LEN:  minl_r <= cfg_pwdata[LEN_W-1:0];
        REG_MAX_LEN:  maxl_r <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      unique case (ri)
        REG_ALPHA0, REG_ALPHA1, REG_ALPHA2, REG_ALPHA3, REG_ALPHA4:
          cfg_prdata = alpha_r[ri];
        REG_ALPHA_SZ: cfg_prdata = 64'(asz_r);
        REG_MIN_LEN:  cfg_prdata = 64'(minl_r);
        REG_MAX_LEN:  cfg_prdata = 64'(maxl_r);
        default: cfg_prdata = '0;
      endcase
    end
  end

  // input held off while the length tables rebuild
  logic [3:0] settle_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 4'(SETTLE_CYC);
    end else if (wr) begin
      settle_r <= 4'(SETTLE_CYC);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 4'd1;
    end
  end

  // saturated effective config
  cfg_eff_t cfg;
  logic [8*ALPHABET_MAX-1:0] alpha_flat;
  always_comb begin
    cfg.n  = (asz_r > DIG_W'(ALPHABET_MAX)) ? DIG_W'(ALPHABET_MAX) : asz_r;
    cfg.lo = (minl_r == '0) ? LEN_W'(1) : minl_r;
    cfg.hi = (maxl_r > LEN_W'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN) : maxl_r;
    cfg.empty = (cfg.n == '0) || (cfg.lo > cfg.hi);
    for (int i = 0; i < ALPHA_REGS; i++) alpha_flat[64*i +: 64] = alpha_r[i];
  end

  // reciprocal of the alphabet size, shared by all digit stages
  logic [RCP_W-1:0] recip;
  assign recip = RECIP_TAB[cfg.n];

  // pipeline advances unless the output holds a word not taken
  logic en;
  logic in_acc;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en && (settle_r == '0);
  assign in_acc = in_tvalid && in_tready;

  logic       v_s [MAX_WORD_LEN+1];
  dig_word_t  w_s [MAX_WORD_LEN+1];

  iwe_locate u_loc (
    .clk(clk), .rst_n(rst_n), .en(en),
    .v_in(in_acc), .idx_in(in_tdata[IDX_W-1:0]), .cfg(cfg),
    .v_out(v_s[0]), .w_out(w_s[0])
  );

  for (genvar g = 0; g < MAX_WORD_LEN; g++) begin : g_dig
    iwe_digit u_dig (
      .clk(clk), .rst_n(rst_n), .en(en), .pos(3'(g)),
      .v_in(v_s[g]), .w_in(w_s[g]), .n(cfg.n), .recip(recip), .alpha(alpha_flat),
      .v_out(v_s[g+1]), .w_out(w_s[g+1])
    );
  end

  assign out_tvalid = v_s[MAX_WORD_LEN];
  assign out_tdata  = {3'b000, w_s[MAX_WORD_LEN].bytes, w_s[MAX_WORD_LEN].len,
                       w_s[MAX_WORD_LEN].ok};

  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (w_s[MAX_WORD_LEN].ok == (w_s[MAX_WORD_LEN].len != '0)))
    else $error("in_range disagrees with length");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("pending word dropped");
  a_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (w_s[MAX_WORD_LEN].rem == '0))
    else $error("offset not fully consumed");

endmodule
